// ===== src/mlqb_pkg.sv =====
// Shared types, widths and codes for the linked-list multi-queue buffer.
`timescale 1ns / 1ps
`default_nettype none

package mlqb_pkg;

	localparam int QUEUES_DEF = 3;
	localparam int NODES_DEF  = 64;

	localparam int SEL_W    = 2;
	localparam int CLASS_W  = 8;
	localparam int GRADE_W  = 16;
	localparam int GOUT_W   = 17;
	localparam int STATUS_W = 2;
	localparam int REC_W    = CLASS_W + GRADE_W;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic signed [GOUT_W-1:0] GRADE_NONE = -17'sd1;

	typedef struct packed {
		logic rd_en;
		logic rec_we;
		logic nxt_we;
	} mlqb_mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/mlqb_node_mem.sv =====
// Node pool storage: record memory and link memory with registered reads.
`timescale 1ns / 1ps
`default_nettype none

module mlqb_node_mem
	import mlqb_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  wire logic                       clk,
	input  wire mlqb_mem_ctl_t              ctl,
	input  wire logic [$clog2(NODES)-1:0]   rd_addr,
	input  wire logic [$clog2(NODES)-1:0]   rec_addr,
	input  wire logic [REC_W-1:0]           rec_data,
	input  wire logic [$clog2(NODES)-1:0]   nxt_addr,
	input  wire logic [$clog2(NODES)-1:0]   nxt_data,
	output logic      [REC_W-1:0]           rd_rec,
	output logic      [$clog2(NODES)-1:0]   rd_nxt
);

	localparam int IW = $clog2(NODES);

	logic [REC_W-1:0] rec_mem [NODES];
	logic [IW-1:0]    nxt_mem [NODES];

	always_ff @(posedge clk) begin
		if (ctl.rec_we) begin
			rec_mem[rec_addr] <= rec_data;
		end
		if (ctl.rd_en) begin
			rd_rec <= rec_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.nxt_we) begin
			nxt_mem[nxt_addr] <= nxt_data;
		end
		if (ctl.rd_en) begin
			rd_nxt <= nxt_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/multi_queue_linked_buffer_core.sv =====
// Top level: several FIFO queues kept as linked lists in one shared node pool.
// Each transaction runs in two steps: accept and node read, then commit and result.
// A new input transaction is accepted only after the previous one commits; in_stall is high in the commit state.
// The commit cycle waits while a previous result is still stalled at the output register.
// Reset clears the queue pointers, flags, free list and counters at once.
// Node memory contents are undefined after reset and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_linked_buffer_core
	import mlqb_pkg::*;
#(
	parameter int QUEUES = QUEUES_DEF,
	parameter int NODES  = NODES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic [SEL_W-1:0]           queue_sel,
	input  wire logic [CLASS_W-1:0]         class_in,
	input  wire logic [GRADE_W-1:0]         grade_in,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [STATUS_W-1:0]        status,
	output logic      [CLASS_W-1:0]         class_out,
	output logic signed [GOUT_W-1:0]        grade_out
);

	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	logic [IW-1:0]     head_q [QUEUES];
	logic [IW-1:0]     tail_q [QUEUES];
	logic [QUEUES-1:0] nonempty_q;
	logic [IW-1:0]     free_head_q;
	logic [CW-1:0]     free_count_q;
	logic [CW-1:0]     fresh_count_q;

	logic               func_q;
	logic [QW-1:0]      sel_q;
	logic [CLASS_W-1:0] class_q;
	logic [GRADE_W-1:0] grade_q;
	logic [IW-1:0]      node_q;
	logic               ok_q;
	logic               from_free_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [CLASS_W-1:0]        class_out_q;
	logic signed [GOUT_W-1:0]  grade_out_q;

	logic          accept;
	logic          out_free;
	logic          commit;
	logic          sel_ok;
	logic [QW-1:0] sel_idx;
	logic          has_free;
	logic          has_fresh;
	logic [IW-1:0] node_d;
	logic          ok_d;
	logic          is_last;

	mlqb_mem_ctl_t    mem_ctl;
	logic [IW-1:0]    nxt_addr;
	logic [IW-1:0]    nxt_data;
	logic [REC_W-1:0] rd_rec;
	logic [IW-1:0]    rd_nxt;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign commit    = (state_q == S_EXEC) && out_free;

	assign sel_ok    = (int'(queue_sel) < QUEUES);
	assign sel_idx   = QW'(queue_sel);
	assign has_free  = (free_count_q != '0);
	assign has_fresh = (fresh_count_q < CW'(NODES));

	always_comb begin
		node_d = free_head_q;
		ok_d   = 1'b0;
		if (func == FUNC_ENQ) begin
			node_d = has_free ? free_head_q : fresh_count_q[IW-1:0];
			ok_d   = sel_ok && (has_free || has_fresh);
		end else begin
			ok_d = sel_ok && nonempty_q[sel_idx];
			if (sel_ok) begin
				node_d = head_q[sel_idx];
			end
		end
	end

	assign is_last = (node_q == tail_q[sel_q]);

	always_comb begin
		mem_ctl.rd_en  = accept;
		mem_ctl.rec_we = commit && ok_q && (func_q == FUNC_ENQ);
		mem_ctl.nxt_we = 1'b0;
		nxt_addr       = node_q;
		nxt_data       = free_head_q;
		if (commit && ok_q) begin
			if (func_q == FUNC_ENQ) begin
				mem_ctl.nxt_we = nonempty_q[sel_q];
				nxt_addr       = tail_q[sel_q];
				nxt_data       = node_q;
			end else begin
				mem_ctl.nxt_we = 1'b1;
			end
		end
	end

	mlqb_node_mem #(
		.NODES (NODES)
	) u_node_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.rd_addr  (node_d),
		.rec_addr (node_q),
		.rec_data ({class_q, grade_q}),
		.nxt_addr (nxt_addr),
		.nxt_data (nxt_data),
		.rd_rec   (rd_rec),
		.rd_nxt   (rd_nxt)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= func;
			sel_q       <= sel_idx;
			class_q     <= class_in;
			grade_q     <= grade_in;
			node_q      <= node_d;
			ok_q        <= ok_d;
			from_free_q <= has_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			nonempty_q    <= '0;
			free_head_q   <= '0;
			free_count_q  <= '0;
			fresh_count_q <= '0;
			for (int i = 0; i < QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit && ok_q) begin
				if (func_q == FUNC_ENQ) begin
					if (!nonempty_q[sel_q]) begin
						head_q[sel_q] <= node_q;
					end
					tail_q[sel_q]     <= node_q;
					nonempty_q[sel_q] <= 1'b1;
					if (from_free_q) begin
						free_head_q  <= rd_nxt;
						free_count_q <= free_count_q - CW'(1);
					end else begin
						fresh_count_q <= fresh_count_q + CW'(1);
					end
				end else begin
					if (is_last) begin
						nonempty_q[sel_q] <= 1'b0;
					end else begin
						head_q[sel_q] <= rd_nxt;
					end
					free_head_q  <= node_q;
					free_count_q <= free_count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (func_q == FUNC_ENQ) begin
				status_q    <= ok_q ? ST_DONE : ST_FULL;
				class_out_q <= '0;
				grade_out_q <= '0;
			end else if (ok_q) begin
				status_q    <= ST_DONE;
				class_out_q <= rd_rec[REC_W-1:GRADE_W];
				grade_out_q <= signed'({1'b0, rd_rec[GRADE_W-1:0]});
			end else begin
				status_q    <= ST_EMPTY;
				class_out_q <= '0;
				grade_out_q <= GRADE_NONE;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign class_out = class_out_q;
	assign grade_out = grade_out_q;

	a_free_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= fresh_count_q)
		else $error("free list holds more nodes than were ever taken");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted transaction did not enter the commit cycle");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result appeared without a commit cycle");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_count_q <= CW'(NODES))
		else $error("fresh node count exceeds the pool size");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the linked-list multi-queue buffer core.
`timescale 1ns / 1ps

module tb_top;
	import mlqb_pkg::*;

	localparam int NODE_W = $clog2(NODES_DEF);

	typedef struct packed {
		logic               func;
		logic [SEL_W-1:0]   sel;
		logic [CLASS_W-1:0] cls;
		logic [GRADE_W-1:0] grd;
	} queue_op_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      st;
		logic [CLASS_W-1:0]       cls;
		logic signed [GOUT_W-1:0] grd;
	} queue_resp_t;

	typedef struct {
		queue_op_t   op;
		int unsigned gap;
	} op_slot_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     func = FUNC_ENQ;
	logic [SEL_W-1:0]         queue_sel = '0;
	logic [CLASS_W-1:0]       class_in = '0;
	logic [GRADE_W-1:0]       grade_in = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [CLASS_W-1:0]       class_out;
	logic signed [GOUT_W-1:0] grade_out;

	multi_queue_linked_buffer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.queue_sel (queue_sel),
		.class_in  (class_in),
		.grade_in  (grade_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.class_out (class_out),
		.grade_out (grade_out)
	);

	always #10 clk = ~clk;

	// Shadow copy of the node pool, the queue pointers and the free list.
	logic [REC_W-1:0]  node_rec  [NODES_DEF];
	logic [NODE_W-1:0] node_link [NODES_DEF];
	logic [NODE_W-1:0] q_head    [QUEUES_DEF];
	logic [NODE_W-1:0] q_tail    [QUEUES_DEF];
	logic              q_busy    [QUEUES_DEF];
	logic [NODE_W-1:0] free_top;
	int unsigned       free_cnt;
	int unsigned       fresh_cnt;

	op_slot_t    pending_ops_q [$];
	queue_resp_t resp_due_q [$];
	int unsigned gap_cnt = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_count = 0;
	int unsigned err_count = 0;
	queue_resp_t want;

	function automatic queue_resp_t apply_queue_op(queue_op_t op);
		queue_resp_t r;
		logic [NODE_W-1:0] n;
		logic got;
		r = '{ST_DONE, '0, '0};
		got = 1'b0;
		n = '0;
		if (op.func == FUNC_ENQ) begin
			if (op.sel < QUEUES_DEF) begin
				if (free_cnt > 0) begin
					n = free_top;
					free_top = node_link[n];
					free_cnt--;
					got = 1'b1;
				end else if (fresh_cnt < NODES_DEF) begin
					n = fresh_cnt[NODE_W-1:0];
					fresh_cnt++;
					got = 1'b1;
				end
			end
			if (!got) begin
				r.st = ST_FULL;
			end else begin
				node_rec[n] = {op.cls, op.grd};
				node_link[n] = '0;
				if (q_busy[op.sel])
					node_link[q_tail[op.sel]] = n;
				else
					q_head[op.sel] = n;
				q_tail[op.sel] = n;
				q_busy[op.sel] = 1'b1;
			end
		end else if (op.sel >= QUEUES_DEF || !q_busy[op.sel]) begin
			r.st = ST_EMPTY;
			r.grd = GRADE_NONE;
		end else begin
			n = q_head[op.sel];
			r.cls = node_rec[n][REC_W-1:GRADE_W];
			r.grd = {1'b0, node_rec[n][GRADE_W-1:0]};
			if (n == q_tail[op.sel])
				q_busy[op.sel] = 1'b0;
			else
				q_head[op.sel] = node_link[n];
			node_link[n] = free_top;
			free_top = n;
			free_cnt++;
		end
		return r;
	endfunction

	function automatic void push_op(logic f, logic [SEL_W-1:0] s, logic [CLASS_W-1:0] c,
		logic [GRADE_W-1:0] g, int unsigned gap);
		op_slot_t slot;
		slot.op = '{f, s, c, g};
		slot.gap = gap;
		pending_ops_q.push_back(slot);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_cnt <= 0;
		end else begin
			if (in_valid && !in_stall)
				resp_due_q.push_back(apply_queue_op('{func, queue_sel, class_in, grade_in}));
			if (!in_valid || !in_stall) begin
				if (gap_cnt != 0) begin
					gap_cnt <= gap_cnt - 1;
					in_valid <= 1'b0;
				end else if (pending_ops_q.size() != 0) begin
					in_valid <= 1'b1;
					func <= pending_ops_q[0].op.func;
					queue_sel <= pending_ops_q[0].op.sel;
					class_in <= pending_ops_q[0].op.cls;
					grade_in <= pending_ops_q[0].op.grd;
					gap_cnt <= pending_ops_q[0].gap;
					void'(pending_ops_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (resp_due_q.size() == 0) begin
					$error("result transaction with no expected result waiting");
					err_count++;
				end else begin
					want = resp_due_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						err_count++;
					end
					if (class_out !== want.cls) begin
						$error("class_out: expected %0d, actual %0d", want.cls, class_out);
						err_count++;
					end
					if (grade_out !== want.grd) begin
						$error("grade_out: expected %0d, actual %0d",
							$signed(want.grd), $signed(grade_out));
						err_count++;
					end
				end
				rx_count++;
				// Some stretches run with no back-pressure; one long hold fills the block.
				if (rx_count == 400)
					rx_wait = 300;
				else if ((rx_count / 100) % 3 == 1)
					rx_wait = 0;
				else
					rx_wait = $urandom_range(0, 8);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= (rx_wait > 0);
		end
	end

	initial begin
		int unsigned mode;
		int unsigned enq_pct;
		logic quiet;
		logic [SEL_W-1:0] s;

		for (int i = 0; i < QUEUES_DEF; i++) begin
			q_head[i] = '0;
			q_tail[i] = '0;
			q_busy[i] = 1'b0;
		end
		free_top = '0;
		free_cnt = 0;
		fresh_cnt = 0;

		// Empty queues, an out-of-range selector, field extremes and free-list reuse.
		push_op(FUNC_DEQ, 2'd0, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd1, 8'hFF, 16'hFFFF, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd2, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd3, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_ENQ, 2'd3, 8'hFF, 16'hFFFF, $urandom_range(0, 8));
		push_op(FUNC_ENQ, 2'd0, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_ENQ, 2'd0, 8'hFF, 16'hFFFF, $urandom_range(0, 8));
		push_op(FUNC_ENQ, 2'd1, 8'hA5, 16'h5A5A, $urandom_range(0, 8));
		push_op(FUNC_ENQ, 2'd2, 8'h5A, 16'hA5A5, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd3, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd0, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd0, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd0, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd1, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_ENQ, 2'd1, 8'h01, 16'h0001, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd2, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd2, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd1, 8'h00, 16'h0000, $urandom_range(0, 8));
		push_op(FUNC_DEQ, 2'd1, 8'h00, 16'h0000, $urandom_range(0, 8));

		// Segments lean toward filling the pool, draining it, or an even mix.
		for (int seg = 0; seg < 14; seg++) begin
			mode = $urandom_range(0, 2);
			enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			quiet = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < 120; k++) begin
				s = ($urandom_range(0, 15) == 0) ? 2'd3 : SEL_W'($urandom_range(0, 2));
				push_op(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ, s,
					CLASS_W'($urandom), GRADE_W'($urandom),
					quiet ? 0 : $urandom_range(0, 8));
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops_q.size() != 0 || in_valid)
			@(negedge clk);
		while (resp_due_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("PASS multi_queue_linked_buffer_core");
		else
			$display("FAIL multi_queue_linked_buffer_core");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL multi_queue_linked_buffer_core");
		$finish;
	end

endmodule

// ===== multi_queue_linked_buffer_core.f =====
src/mlqb_pkg.sv
src/mlqb_node_mem.sv
src/multi_queue_linked_buffer_core.sv
test/tb_top.sv
